>>> src/lrupr_pkg.sv
// Package for the LRU page replacement block: widths, codes and helpers.
package lrupr_pkg;

	// fixed field widths
	localparam int PAGE_W  = 16;
	localparam int FIDX_W  = 5;
	localparam int FAULT_W = 16;
	localparam int FIU_W   = 6;

	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;
	localparam logic [FIU_W-1:0]   FIU_RESET = 6'd32;

	// defaults for the top level parameters
	localparam int DEF_FRAMES    = 32;
	localparam int DEF_PAGE_BITS = 16;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_FIU = 1'b0;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} st_t;

	// width of an index or rank over f frames
	function automatic int idx_width(input int f);
		return (f > 1) ? $clog2(f) : 1;
	endfunction

	// width of the scan record handed along the cell chain
	function automatic int rec_width(input int f, input int pb);
		return 2 + 3 * idx_width(f) + 2 * idx_width(f) + pb;
	endfunction

	// width of the update word broadcast to all cells
	function automatic int upd_width(input int f, input int pb);
		return 2 + idx_width(f) + idx_width(f) + 1 + pb;
	endfunction

endpackage

>>> src/lrupr_if.sv
// Channel interfaces: page references in, replacement results out.

interface lrupr_req_if
	import lrupr_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] page;
	logic              start_new;

	modport source (output valid, page, start_new, input ready);
	modport sink   (input valid, page, start_new, output ready);
endinterface

interface lrupr_rsp_if
	import lrupr_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               hit;
	logic [FIDX_W-1:0]  frame_index;
	logic               evicted_valid;
	logic [PAGE_W-1:0]  evicted_page;
	logic [FAULT_W-1:0] fault_count;

	modport source (output valid, hit, frame_index, evicted_valid, evicted_page, fault_count,
		input ready);
	modport sink   (input valid, hit, frame_index, evicted_valid, evicted_page, fault_count,
		output ready);
endinterface

>>> src/lrupr_apb.sv
// APB-style register port holding the frames-in-use setting.
module lrupr_apb
	import lrupr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [FIU_W-1:0]  fiu
);
	logic [FIU_W-1:0] fiu_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign fiu    = fiu_q;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= FIU_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_FIU: fiu_q <= pwdata[FIU_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[2])
			REG_FIU: prdata = APB_DW'(fiu_q);
			default: prdata = '0;
		endcase
	end

endmodule

>>> src/lrupr_cell.sv
// One frame cell: holds page, valid and rank; scans and updates in place.
module lrupr_cell
	import lrupr_pkg::*;
#(
	parameter int FRAMES    = DEF_FRAMES,
	parameter int PAGE_BITS = DEF_PAGE_BITS,
	parameter int K         = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 clr,
	input  logic [PAGE_BITS-1:0]                 page_b,
	input  logic [$clog2(FRAMES+1)-1:0]          act_cnt,
	input  logic                                 tok_i,
	input  logic [rec_width(FRAMES, PAGE_BITS)-1:0] rec_i,
	output logic                                 tok_o,
	output logic [rec_width(FRAMES, PAGE_BITS)-1:0] rec_o,
	input  logic [upd_width(FRAMES, PAGE_BITS)-1:0] upd_i
);
	localparam int IDX_W  = idx_width(FRAMES);
	localparam int RANK_W = idx_width(FRAMES);
	localparam int CNT_W  = $clog2(FRAMES + 1);
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);
	localparam logic [IDX_W-1:0]  MY_IDX   = IDX_W'(K);

	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     hit_idx;
		logic [RANK_W-1:0]    hit_rank;
		logic                 empty;
		logic [IDX_W-1:0]     empty_idx;
		logic [RANK_W-1:0]    best_rank;
		logic [IDX_W-1:0]     best_idx;
		logic [PAGE_BITS-1:0] best_page;
	} rec_t;

	typedef struct packed {
		logic                 commit;
		logic                 write;
		logic [IDX_W-1:0]     slot;
		logic [RANK_W:0]      limit;
		logic [PAGE_BITS-1:0] page;
	} upd_t;

	logic [PAGE_BITS-1:0] pg_q;
	logic                 val_q;
	logic [RANK_W-1:0]    rank_q;
	logic                 tok_q;
	rec_t                 rec_q;
	rec_t                 r_in;
	rec_t                 r_out;
	upd_t                 upd;
	logic                 act;
	logic                 mine;
	logic                 bump;

	assign r_in  = rec_t'(rec_i);
	assign upd   = upd_t'(upd_i);
	assign act   = CNT_W'(K) < act_cnt;
	assign tok_o = tok_q;
	assign rec_o = rec_q;

	// fold this frame into the passing record
	always_comb begin
		r_out = r_in;
		if (act && val_q && (pg_q == page_b) && !r_in.found) begin
			r_out.found    = 1'b1;
			r_out.hit_idx  = MY_IDX;
			r_out.hit_rank = rank_q;
		end
		if (act && !val_q && !r_in.empty) begin
			r_out.empty     = 1'b1;
			r_out.empty_idx = MY_IDX;
		end
		if (act && ((K == 0) || (rank_q > r_in.best_rank))) begin
			r_out.best_rank = rank_q;
			r_out.best_idx  = MY_IDX;
			r_out.best_page = pg_q;
		end
	end

	// token and record move one cell per cycle; record holds after the token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_i;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_i) begin
			rec_q <= r_out;
		end
	end

	// update decision for this frame
	assign mine = upd.slot == MY_IDX;
	assign bump = act && val_q && !mine && ({1'b0, rank_q} < upd.limit) &&
		(rank_q < RANK_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q  <= 1'b0;
			rank_q <= '0;
		end else if (clr) begin
			val_q  <= 1'b0;
			rank_q <= '0;
		end else if (upd.commit) begin
			if (mine) begin
				rank_q <= '0;
				if (upd.write) begin
					val_q <= 1'b1;
				end
			end else if (bump) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.commit && mine && upd.write) begin
			pg_q <= upd.page;
		end
	end

endmodule

>>> src/lru_page_replacement_top.sv
// LRU page replacement, fully associative over a chain of frame cells.
// A reference is taken in the idle state; the scan token then walks the cell chain, and the result
// is committed to the output register before the sequencer returns to idle for the next reference.
// The output register lets the next reference in while a result waits to be taken.
// Reset: all frames invalid, ranks and fault count zero, frames_in_use at 32.
module lru_page_replacement_top
	import lrupr_pkg::*;
#(
	parameter int FRAMES    = DEF_FRAMES,
	parameter int PAGE_BITS = DEF_PAGE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	lrupr_req_if.sink         refs,
	lrupr_rsp_if.source       res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);
	localparam int IDX_W  = idx_width(FRAMES);
	localparam int RANK_W = idx_width(FRAMES);
	localparam int CNT_W  = $clog2(FRAMES + 1);
	localparam int REC_W  = rec_width(FRAMES, PAGE_BITS);
	localparam int UPD_W  = upd_width(FRAMES, PAGE_BITS);

	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     hit_idx;
		logic [RANK_W-1:0]    hit_rank;
		logic                 empty;
		logic [IDX_W-1:0]     empty_idx;
		logic [RANK_W-1:0]    best_rank;
		logic [IDX_W-1:0]     best_idx;
		logic [PAGE_BITS-1:0] best_page;
	} rec_t;

	typedef struct packed {
		logic                 commit;
		logic                 write;
		logic [IDX_W-1:0]     slot;
		logic [RANK_W:0]      limit;
		logic [PAGE_BITS-1:0] page;
	} upd_t;

	st_t                  state_q;
	st_t                  state_nx;
	logic                 in_acc;
	logic                 out_free;
	logic                 commit;
	logic                 inject_q;
	logic                 clr;
	logic [PAGE_BITS-1:0] page_q;
	logic [FIU_W-1:0]     fiu;
	logic [CNT_W-1:0]     act_cnt_q;
	logic [FAULT_W-1:0]   fault_q;
	logic [FAULT_W-1:0]   fault_nx;
	logic [FRAMES:0]      tok_c;
	logic [REC_W-1:0]     rec_c [FRAMES+1];
	rec_t                 rl;
	upd_t                 upd;
	logic                 ev_valid;

	logic                 out_valid_q;
	logic                 out_hit_q;
	logic [FIDX_W-1:0]    out_idx_q;
	logic                 out_ev_q;
	logic [PAGE_W-1:0]    out_evpg_q;
	logic [FAULT_W-1:0]   out_fault_q;

	// configuration register
	lrupr_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.fiu     (fiu)
	);

	// active frame count, clamped to 1..FRAMES
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_cnt_q <= CNT_W'(FRAMES);
		end else if (fiu == '0) begin
			act_cnt_q <= CNT_W'(1);
		end else if (32'(fiu) > 32'(FRAMES)) begin
			act_cnt_q <= CNT_W'(FRAMES);
		end else begin
			act_cnt_q <= CNT_W'(fiu);
		end
	end

	// sequencer: next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (refs.valid) state_nx = ST_SCAN;
			ST_SCAN:   if (tok_c[FRAMES]) state_nx = ST_COMMIT;
			ST_COMMIT: if (out_free) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		refs.ready = 1'b0;
		commit     = 1'b0;
		unique case (state_q)
			ST_IDLE:   refs.ready = 1'b1;
			ST_SCAN:   ;
			ST_COMMIT: commit = out_free;
			default:   ;
		endcase
	end

	assign in_acc   = refs.valid && refs.ready;
	assign out_free = !out_valid_q || res.ready;
	assign clr      = in_acc && refs.start_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			inject_q <= 1'b0;
		end else begin
			state_q  <= state_nx;
			inject_q <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			page_q <= PAGE_BITS'(refs.page);
		end
	end

	// cell chain
	assign tok_c[0] = inject_q;
	assign rec_c[0] = '0;

	for (genvar k = 0; k < FRAMES; k++) begin : g_cell
		lrupr_cell #(
			.FRAMES    (FRAMES),
			.PAGE_BITS (PAGE_BITS),
			.K         (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (clr),
			.page_b  (page_q),
			.act_cnt (act_cnt_q),
			.tok_i   (tok_c[k]),
			.rec_i   (rec_c[k]),
			.tok_o   (tok_c[k+1]),
			.rec_o   (rec_c[k+1]),
			.upd_i   (UPD_W'(upd))
		);
	end

	// decision from the record at the end of the chain
	assign rl = rec_t'(rec_c[FRAMES]);

	always_comb begin
		upd.commit = commit;
		upd.page   = page_q;
		ev_valid   = 1'b0;
		if (rl.found) begin
			upd.write = 1'b0;
			upd.slot  = rl.hit_idx;
			upd.limit = {1'b0, rl.hit_rank};
		end else if (rl.empty) begin
			upd.write = 1'b1;
			upd.slot  = rl.empty_idx;
			upd.limit = (RANK_W + 1)'(FRAMES);
		end else begin
			upd.write = 1'b1;
			upd.slot  = rl.best_idx;
			upd.limit = {1'b0, rl.best_rank};
			ev_valid  = 1'b1;
		end
	end

	// fault counter, saturating
	always_comb begin
		fault_nx = fault_q;
		if (!rl.found && (fault_q != FAULT_MAX)) begin
			fault_nx = fault_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= '0;
		end else if (clr) begin
			fault_q <= '0;
		end else if (commit) begin
			fault_q <= fault_nx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_hit_q   <= rl.found;
			out_idx_q   <= FIDX_W'(upd.slot);
			out_ev_q    <= ev_valid;
			out_evpg_q  <= ev_valid ? PAGE_W'(rl.best_page) : '0;
			out_fault_q <= fault_nx;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.hit           = out_hit_q;
	assign res.frame_index   = out_idx_q;
	assign res.evicted_valid = out_ev_q;
	assign res.evicted_page  = out_evpg_q;
	assign res.fault_count   = out_fault_q;

`ifndef SYNTHESIS
	// at most one scan token in the chain at any time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_c))
		else $error("more than one scan token in the cell chain");

	// the token leaves the chain only while the sequencer waits for it
	a_tok_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_c[FRAMES] |-> state_q == ST_SCAN)
		else $error("scan token left the chain outside the scan state");

	// a fault below saturation moves the counter up by one
	a_fault_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !rl.found && (fault_q != FAULT_MAX) |=>
		fault_q == $past(fault_q) + 1'b1)
		else $error("fault counter did not advance on a fault");

	// a hit never reports an eviction
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_hit_q |-> !out_ev_q && (out_evpg_q == '0))
		else $error("eviction reported on a hit");
`endif

endmodule
